// File: hw/rtl/oderk_pkg.sv
// shared types, constants and saturation helpers for the ode stepper
// no dependencies
package oderk_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned DVD_W  = 45;   // biased dividend width of the serial divider
  localparam int unsigned BIAS_SH = 40;  // bias shift that keeps the dividend positive

  // configuration register indexes
  localparam logic [2:0] REG_START_X    = 3'd0;
  localparam logic [2:0] REG_START_Y    = 3'd1;
  localparam logic [2:0] REG_STEP_SIZE  = 3'd2;
  localparam logic [2:0] REG_STEP_COUNT = 3'd3;
  localparam logic [2:0] REG_METHOD     = 3'd4;

  localparam logic METHOD_RK = 1'b0;
  localparam logic METHOD_AB = 1'b1;

  // adams-bashforth weights and divisors
  localparam logic [30:0] AB_C0 = 31'd55;
  localparam logic [30:0] AB_C1 = 31'd59;
  localparam logic [30:0] AB_C2 = 31'd37;
  localparam logic [30:0] AB_C3 = 31'd9;
  localparam logic [4:0]  DIV_AB = 5'd24;
  localparam logic [4:0]  DIV_RK = 5'd6;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  function automatic word_t sat64(input acc_t v);
    if (v > acc_t'(64'sd2147483647)) begin
      return word_t'(32'sh7fffffff);
    end else if (v < -acc_t'(64'sd2147483648)) begin
      return word_t'(32'sh80000000);
    end else begin
      return word_t'(v[WORD_W-1:0]);
    end
  endfunction

  function automatic word_t sat33(input logic signed [WORD_W:0] v);
    if (v[WORD_W] != v[WORD_W-1]) begin
      return v[WORD_W] ? word_t'(32'sh80000000) : word_t'(32'sh7fffffff);
    end else begin
      return word_t'(v[WORD_W-1:0]);
    end
  endfunction

  function automatic word_t add_sat(input word_t a, input word_t b);
    return sat33(33'(a) + 33'(b));
  endfunction

  function automatic word_t sub_sat(input word_t a, input word_t b);
    return sat33(33'(a) - 33'(b));
  endfunction

endpackage

// File: hw/rtl/ode_rk4_adams_bashforth_stepper_unit.sv
// top level of the ode stepper: sequencer, bit-serial multiply-accumulate,
// bit-serial constant divider and output register; uses oderk_pkg
//
// channel  | dir | data
// in_      | in  | tdata[0] restart, tdata[7:1] zero
// out_     | out | tdata[10:0] point_index, [42:11] x_value, [74:43] y_value; tlast last
// cfg_     | in  | cfg_we, cfg_index (register number), cfg_wdata
//
// a restart item goes straight to the output stage; an advance item runs
// runge-kutta as four serial multiplies plus a serial divide,
// or adams-bashforth as five multiplies and one divide
// an advance item while no run is active is accepted and dropped, no transfer out
// reset is synchronous, active low; a result waits in the output register
// while the next item is already accepted and processed
module ode_rk4_adams_bashforth_stepper_unit
  import oderk_pkg::*;
#(
  parameter int MAX_STEPS = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [10:0] point_index, [42:11] x_value, [74:43] y_value
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int IW   = $clog2(MAX_STEPS + 1);
  localparam int IDXW = (IW > 11) ? IW : 11;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_RK1  = 4'd3;
  localparam logic [3:0] S_RK2  = 4'd4;
  localparam logic [3:0] S_RK3  = 4'd5;
  localparam logic [3:0] S_RK4  = 4'd6;
  localparam logic [3:0] S_RK5  = 4'd7;
  localparam logic [3:0] S_RKY  = 4'd8;
  localparam logic [3:0] S_AB1  = 4'd9;
  localparam logic [3:0] S_AB2  = 4'd10;
  localparam logic [3:0] S_AB3  = 4'd11;
  localparam logic [3:0] S_AB4  = 4'd12;
  localparam logic [3:0] S_AB5  = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  // configuration
  word_t       start_x_r, start_y_r;
  logic [30:0] step_size_r;
  logic [10:0] step_count_r;
  logic        method_r;

  // integrator state
  word_t            x_r, y_r, f0_r, ynew_r;
  word_t            hist_r [3];
  logic [IDXW-1:0]  idx_r;
  logic             running_r, last_r;
  logic signed [35:0] ksum_r;

  // sequencer
  logic [3:0] state_r, ret_r;

  // marks the adams-bashforth path so S_RKY adds h*w instead of the quotient
  logic ab_path_r;

  // serial multiply-accumulate
  acc_t        acc_r, mc_r;
  logic [30:0] mp_r;
  logic        msub_r;
  logic [4:0]  mcnt_r;

  // serial divider
  logic [DVD_W-1:0] dvd_r;
  logic [4:0]       rem_r, div_r;
  logic [5:0]       dcnt_r;

  // output register
  logic        out_valid_r, out_last_r;
  logic [10:0] out_idx_r;
  word_t       out_x_r, out_y_r;

  logic            in_xfer, out_free, restart;
  logic [IDXW-1:0] limit;
  word_t           h_w, hh_w, xm_w, xh_w, rnd_w, b_w, q_sat_w;
  acc_t            rnd_p;
  logic signed [DVD_W:0] q_signed;
  logic [DVD_W-1:0] ab_dvd, rk_dvd;
  logic [5:0]       dtrial;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign restart   = in_tdata[0];
  assign out_free  = !out_valid_r || out_tready;

  assign limit = (IDXW'(step_count_r) > IDXW'(MAX_STEPS)) ? IDXW'(MAX_STEPS)
                                                          : IDXW'(step_count_r);

  assign h_w   = word_t'({1'b0, step_size_r});
  assign hh_w  = word_t'({2'b0, step_size_r[30:1]});
  assign xm_w  = add_sat(x_r, hh_w);
  assign xh_w  = add_sat(x_r, h_w);

  // round to nearest (ties up), floor shift, saturate
  assign rnd_p = acc_r + (acc_t'(1) <<< (FRAC_BITS - 1));
  assign rnd_w = sat64(rnd_p >>> FRAC_BITS);

  // next multiplicand for k2, k3 and k4
  always_comb begin
    case (state_r)
      S_RK2:   b_w = sub_sat(xm_w, add_sat(y_r, rnd_w >>> 1));
      S_RK3:   b_w = sub_sat(xm_w, add_sat(y_r, rnd_w >>> 1));
      default: b_w = sub_sat(xh_w, add_sat(y_r, rnd_w));
    endcase
  end

  // dividends biased by divisor << BIAS_SH so they stay positive
  assign ab_dvd = acc_r[DVD_W-1:0] + DVD_W'(12) + (DVD_W'(DIV_AB) << BIAS_SH);
  assign rk_dvd = DVD_W'(ksum_r) + DVD_W'(3) + (DVD_W'(DIV_RK) << BIAS_SH);
  assign q_signed = $signed({1'b0, dvd_r}) - $signed((DVD_W+1)'(1) << BIAS_SH);
  assign q_sat_w  = sat64(acc_t'(q_signed));

  assign dtrial = {rem_r, dvd_r[DVD_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r    <= '0;
      start_y_r    <= word_t'(32'sd65536);
      step_size_r  <= 31'd6554;
      step_count_r <= 11'd10;
      method_r     <= METHOD_AB;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_X:    start_x_r    <= word_t'(cfg_wdata);
        REG_START_Y:    start_y_r    <= word_t'(cfg_wdata);
        REG_STEP_SIZE:  step_size_r  <= cfg_wdata[30:0];
        REG_STEP_COUNT: step_count_r <= cfg_wdata[10:0];
        REG_METHOD:     method_r     <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      running_r   <= 1'b0;
      last_r      <= 1'b0;
      idx_r       <= '0;
      x_r         <= '0;
      y_r         <= '0;
      hist_r[0]   <= '0;
      hist_r[1]   <= '0;
      hist_r[2]   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the output stage reloads the register itself when it is freed
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (restart) begin
              x_r       <= start_x_r;
              y_r       <= start_y_r;
              hist_r[0] <= '0;
              hist_r[1] <= '0;
              hist_r[2] <= '0;
              idx_r     <= '0;
              last_r    <= (limit == '0);
              running_r <= (limit != '0);
              state_r   <= S_OUT;
            end else if (running_r) begin
              f0_r  <= sub_sat(x_r, y_r);
              idx_r <= idx_r + 1'b1;
              acc_r <= '0;
              mc_r  <= acc_t'(sub_sat(x_r, y_r));
              mcnt_r <= 5'd30;
              if (method_r == METHOD_AB && (idx_r + 1'b1) >= IDXW'(4)) begin
                mp_r    <= AB_C0;
                msub_r  <= 1'b0;
                ret_r   <= S_AB1;
              end else begin
                mp_r    <= step_size_r;
                msub_r  <= 1'b0;
                ret_r   <= S_RK2;
              end
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mp_r[0]) begin
            acc_r <= msub_r ? acc_r - mc_r : acc_r + mc_r;
          end
          mc_r   <= mc_r <<< 1;
          mp_r   <= mp_r >> 1;
          mcnt_r <= mcnt_r - 1'b1;
          if (mcnt_r == '0) begin
            state_r <= ret_r;
          end
        end
        S_DIV: begin
          if (dtrial >= {1'b0, div_r}) begin
            rem_r <= 5'(dtrial - {1'b0, div_r});
            dvd_r <= {dvd_r[DVD_W-2:0], 1'b1};
          end else begin
            rem_r <= dtrial[4:0];
            dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r - 1'b1;
          if (dcnt_r == '0) begin
            state_r <= ret_r;
          end
        end
        S_RK2, S_RK3, S_RK4: begin
          // rnd_w holds k1, k2 or k3; doubled weight for k2 and k3
          if (state_r == S_RK2) begin
            ksum_r <= 36'(rnd_w);
          end else begin
            ksum_r <= ksum_r + (36'(rnd_w) <<< 1);
          end
          acc_r   <= '0;
          mc_r    <= acc_t'(b_w);
          mp_r    <= step_size_r;
          msub_r  <= 1'b0;
          mcnt_r  <= 5'd30;
          ret_r   <= (state_r == S_RK2) ? S_RK3 : (state_r == S_RK3) ? S_RK4 : S_RK5;
          state_r <= S_MUL;
        end
        S_RK5: begin
          ksum_r  <= ksum_r + 36'(rnd_w);
          state_r <= S_RK1;
        end
        S_RK1: begin
          dvd_r   <= rk_dvd;
          div_r   <= DIV_RK;
          rem_r   <= '0;
          dcnt_r  <= 6'(DVD_W - 1);
          ret_r   <= S_RKY;
          state_r <= S_DIV;
        end
        S_RKY: begin
          // adams-bashforth adds the rounded h*w, runge-kutta the quotient
          if (ab_path_r) begin
            ynew_r <= add_sat(y_r, rnd_w);
          end else begin
            ynew_r <= sat64(acc_t'(y_r) + acc_t'(q_signed));
          end
          state_r <= S_FIN;
        end
        S_AB1, S_AB2, S_AB3: begin
          mc_r    <= acc_t'(hist_r[2'(state_r - S_AB1)]);
          mp_r    <= (state_r == S_AB1) ? AB_C1 : (state_r == S_AB2) ? AB_C2 : AB_C3;
          msub_r  <= (state_r != S_AB2);
          mcnt_r  <= 5'd30;
          ret_r   <= (state_r == S_AB1) ? S_AB2 : (state_r == S_AB2) ? S_AB3 : S_AB4;
          state_r <= S_MUL;
        end
        S_AB4: begin
          if (ret_r == S_AB4) begin
            dvd_r   <= ab_dvd;
            div_r   <= DIV_AB;
            rem_r   <= '0;
            dcnt_r  <= 6'(DVD_W - 1);
            ret_r   <= S_AB5;
            state_r <= S_DIV;
          end
        end
        S_AB5: begin
          if (ret_r == S_AB5) begin
            // w is ready, multiply it by h
            acc_r   <= '0;
            mc_r    <= acc_t'(q_sat_w);
            mp_r    <= step_size_r;
            msub_r  <= 1'b0;
            mcnt_r  <= 5'd30;
            ret_r   <= S_RKY;
            state_r <= S_MUL;
          end
        end
        S_FIN: begin
          hist_r[2] <= hist_r[1];
          hist_r[1] <= hist_r[0];
          hist_r[0] <= f0_r;
          x_r       <= xh_w;
          y_r       <= ynew_r;
          last_r    <= (idx_r >= limit);
          if (idx_r >= limit) begin
            running_r <= 1'b0;
          end
          state_r   <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_last_r  <= last_r;
            out_idx_r   <= idx_r[10:0];
            out_x_r     <= x_r;
            out_y_r     <= y_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ab_path_r <= 1'b0;
    end else if (state_r == S_IDLE && in_xfer) begin
      ab_path_r <= (method_r == METHOD_AB) && ((idx_r + 1'b1) >= IDXW'(4));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'b0, out_y_r, out_x_r, out_idx_r};

  a_idle_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !restart && !running_r |=> state_r == S_IDLE)
    else $error("advance while no run active must give no work");

  a_restart_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && restart |=> state_r == S_OUT && idx_r == '0)
    else $error("restart must go straight to the output stage at point 0");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < div_r)
    else $error("divider remainder out of range");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("finished point not loaded into output register");

endmodule
